// ----- rtl/sqb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared types, request codes and status codes for the stack/queue buffer.
// ----------------------------------------------------------------------------
package sqb_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   localparam int TYPE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;

   // request codes
   localparam logic [TYPE_W-1:0] OP_APPEND = 3'd0;
   localparam logic [TYPE_W-1:0] OP_PUSH   = 3'd1;
   localparam logic [TYPE_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [TYPE_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [TYPE_W-1:0] OP_READ   = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } sqb_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // perform the operation and the slot access
   } sqb_cmd_type;

endpackage

// ----- rtl/sqb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_ctrl
// Sequencer: capture a request, execute it, then strobe the result.
// ----------------------------------------------------------------------------
module sqb_ctrl
   import sqb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   output sqb_cmd_type cmd
);

   sqb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/sqb_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_dpath
// Ring storage, head pointer, element count and result registers.
// ----------------------------------------------------------------------------
module sqb_dpath
   import sqb_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   localparam int CW        = $clog2(CAPACITY + 1)
)
(
   input  logic               clock,
   input  logic               reset,
   input  sqb_cmd_type        cmd,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]   req_position,
   output logic [VALUE_W-1:0] rsp_data,
   output logic [CW-1:0]      rsp_occupancy,
   output logic               rsp_empty_res,
   output logic [STAT_W-1:0]  rsp_status
);

   localparam int PW   = $clog2(CAPACITY);
   localparam int SW   = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   logic [SW-1:0]     slots_ff [CAPACITY];

   logic [TYPE_W-1:0] type_ff;
   logic [SW-1:0]     value_ff;
   logic [POS_W-1:0]  pos_ff;

   logic [PW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;

   logic [SW-1:0]     rd_data_ff;
   logic              data_sel_ff;
   logic [CW-1:0]     occ_ff;
   logic              empty_ff;
   logic [STAT_W-1:0] status_ff, status_in;

   logic              is_full, is_empty, in_range;
   logic [CMPW-1:0]   offset;
   logic [CMPW:0]     sum, ring;
   logic [PW-1:0]     ring_addr, mem_addr;
   logic              wr_en, rd_en;

   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign in_range = (CMPW'(pos_ff) < CMPW'(count_ff));

   // offset from the head for the one ring add this request needs
   always_comb begin
      case (type_ff)
         OP_APPEND: offset = CMPW'(count_ff);
         OP_PUSH:   offset = CMPW'(CAPACITY - 1);
         OP_REMOVE: offset = CMPW'(1);
         OP_READ:   offset = CMPW'(pos_ff);
         default:   offset = '0;
      endcase
   end

   // both operands stay below CAPACITY, so one conditional subtract wraps
   assign sum       = (CMPW+1)'(head_ff) + (CMPW+1)'(offset);
   assign ring      = (sum >= (CMPW+1)'(CAPACITY)) ? sum - (CMPW+1)'(CAPACITY) : sum;
   assign ring_addr = ring[PW-1:0];

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STAT_OK;
      mem_addr  = ring_addr;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      case (type_ff)
         OP_APPEND: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               head_in  = ring_addr;
               count_in = count_ff + CW'(1);
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en    = 1'b1;
               mem_addr = head_ff;
               head_in  = ring_addr;
               count_in = count_ff - CW'(1);
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         OP_READ: begin
            if (!in_range) begin
               status_in = STAT_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         value_ff <= req_value[SW-1:0];
         pos_ff   <= req_position;
      end
   end

   // pointer and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // slot storage, one access per request
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         slots_ff[mem_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rd_en) begin
         rd_data_ff <= slots_ff[mem_addr];
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         data_sel_ff <= rd_en;
         occ_ff      <= count_in;
         empty_ff    <= (count_in == '0);
         status_ff   <= status_in;
      end
   end

   assign rsp_data      = data_sel_ff ? VALUE_W'(rd_data_ff) : '0;
   assign rsp_occupancy = occ_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_status    = status_ff;

endmodule

// ----- rtl/stack_queue_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_buffer
// Bounded double-ended buffer kept as a ring: append, push, remove head,
// clear and indexed read, one result item per request item.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            fields
//   --------  ---------  -------------------  -------------------------------
//   request   in         start && !busy       req_type, req_value,
//                                             req_position
//   response  out        rsp_strobe (1 cyc)   rsp_data, rsp_occupancy,
//                                             rsp_empty_res, rsp_status
//
// Each item passes through capture, execute (pointer/count update plus
// at most one slot access on the one-port ring memory), then the result strobe.
// busy is low again in the cycle after the strobe, so a new item is accepted
// only once the previous one has finished.
// Reset clears the head pointer, the count and the sequencer; the slots are
// not cleared and are never read before they are written.
// The response side cannot stall: the result shows for exactly one cycle.
//
module stack_queue_buffer
   import sqb_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   localparam int CW        = $clog2(CAPACITY + 1)
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]   req_position,
   output logic               rsp_strobe,
   output logic [VALUE_W-1:0] rsp_data,
   output logic [CW-1:0]      rsp_occupancy,
   output logic               rsp_empty_res,
   output logic [STAT_W-1:0]  rsp_status
);

   sqb_cmd_type cmd;

   // sequencer: drives busy, the strobe and the datapath commands
   sqb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // ring storage, head pointer, count and result registers
   sqb_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_type),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_data      (rsp_data),
      .rsp_occupancy (rsp_occupancy),
      .rsp_empty_res (rsp_empty_res),
      .rsp_status    (rsp_status)
   );

endmodule

// ----- rtl/sqb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqb_checker
// Port-level checks on the stack/queue buffer, bound to the top level.
// ----------------------------------------------------------------------------
module sqb_checker
   import sqb_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   localparam int CW      = $clog2(CAPACITY + 1)
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [TYPE_W-1:0]  req_type,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]   req_position,
   input  logic               rsp_strobe,
   input  logic [VALUE_W-1:0] rsp_data,
   input  logic [CW-1:0]      rsp_occupancy,
   input  logic               rsp_empty_res,
   input  logic [STAT_W-1:0]  rsp_status
);

   // every accepted item is followed by its result strobe, after the execute step
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result strobe missing after accepted item");

   // no new item is taken while one is in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // empty flag agrees with the reported count
   a_empty_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_empty_res == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   // errors return no data
   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |-> (rsp_data == '0))
      else $error("data nonzero on error status");

   // count never exceeds the capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_occupancy <= CW'(CAPACITY)))
      else $error("occupancy above capacity");

endmodule

bind stack_queue_buffer sqb_checker #(.CAPACITY(CAPACITY)) u_sqb_checker (.*);
